// ===== sv/fuzzy_angle_rate_controller_macros.svh =====
// assertion helpers
`ifndef FUZZY_ANGLE_RATE_CONTROLLER_MACROS_SVH
`define FUZZY_ANGLE_RATE_CONTROLLER_MACROS_SVH

`define FZC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fzc assertion failed");

`define FZC_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("fzc assertion failed");

`endif

// ===== sv/fzc_pkg.sv =====
package fzc_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int FRACTION_BITS  = 8;
  localparam int POINT_BITS     = 12;
  localparam int SETS           = 5;
  localparam int RULES          = SETS * SETS;
  localparam int LANES          = 2 * SETS;
  localparam int CFG_BITS       = 5 * POINT_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CODE_BITS      = 3;
  localparam int RULES_LOW      = 13;
  localparam int RULE_LOW_BITS  = RULES_LOW * CODE_BITS;
  localparam int RULE_HIGH_BITS = (RULES - RULES_LOW) * CODE_BITS;
  localparam int DRIVE_BITS     = 13;
  localparam int WEIGHT_BIG     = 10;

  localparam int DIFF_BITS   = ((SAMPLE_BITS > POINT_BITS) ? SAMPLE_BITS : POINT_BITS) + 1;
  localparam int SPAN_BITS   = DIFF_BITS - 1;
  localparam int DIV_STEPS   = FRACTION_BITS;
  localparam int MF_BITS     = FRACTION_BITS + 1;
  localparam int SQ_BITS     = 2 * FRACTION_BITS + 1;
  localparam int PART_BITS   = SQ_BITS + 3;
  localparam int ACC_BITS    = SQ_BITS + 5;
  localparam int SQRT_STEPS  = (ACC_BITS + 1) / 2;
  localparam int SQRT_BITS   = ACC_BITS + 1;
  localparam int STR_BITS    = SQRT_STEPS;
  localparam int DEN_BITS    = STR_BITS + 3;
  localparam int MAG_BITS    = STR_BITS + 4;
  localparam int QUO_STEPS   = FRACTION_BITS + 4;
  localparam int DVD_BITS    = MAG_BITS + FRACTION_BITS + 1;
  localparam int QDEPTH      = 2;

  localparam int BACK_STAGES = DIV_STEPS + 3 + SQRT_STEPS + 1 + QUO_STEPS + 1;
  localparam int LATENCY     = BACK_STAGES + 2;

  localparam logic [RULE_LOW_BITS-1:0]  RULE_LOW_RESET  = 39'd146484236800;
  localparam logic [RULE_HIGH_BITS-1:0] RULE_HIGH_RESET = 36'd39249359459;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_ANGLE_A, CFG_ANGLE_B, CFG_ANGLE_C,
    CFG_RATE_A, CFG_RATE_B, CFG_RATE_C,
    CFG_RULE_LOW, CFG_RULE_HIGH
  } cfg_index_e;

  typedef struct packed {
    logic [2:0][CFG_BITS-1:0]   angle;
    logic [2:0][CFG_BITS-1:0]   rate;
    logic [RULE_LOW_BITS-1:0]   rule_low;
    logic [RULE_HIGH_BITS-1:0]  rule_high;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] angle_sample;
    logic signed [SAMPLE_BITS-1:0] rate_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DRIVE_BITS-1:0] drive_value;
    logic                         no_rule_fired;
  } out_item_t;

  typedef struct packed {
    logic [LANES-1:0]                one;
    logic [LANES-1:0][SPAN_BITS-1:0] num;
    logic [LANES-1:0][SPAN_BITS-1:0] den;
  } front_item_t;

  function automatic logic signed [POINT_BITS-1:0] get_point(input cfg_t c, input int axis,
                                                             input int k);
    logic [CFG_BITS-1:0] r;
    if (axis == 0) r = c.angle[k / 5];
    else r = c.rate[k / 5];
    return r[(k % 5) * POINT_BITS +: POINT_BITS];
  endfunction

  function automatic logic [CODE_BITS-1:0] rule_code(input cfg_t c, input int r);
    if (r < RULES_LOW) return c.rule_low[CODE_BITS * r +: CODE_BITS];
    else return c.rule_high[CODE_BITS * (r - RULES_LOW) +: CODE_BITS];
  endfunction

endpackage

// ===== sv/fzc_front.sv =====
module fzc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  fzc_pkg::in_item_t   item_i,
  output logic                busy_o,
  input  fzc_pkg::cfg_t       cfg_i,
  output logic                valid_o,
  output fzc_pkg::front_item_t item_o,
  input  logic                ready_i
);
  import fzc_pkg::*;

  logic        valid_q, valid_d, load;
  front_item_t item_q, item_d;

  assign load   = !valid_q || ready_i;
  assign busy_o = !load;
  assign valid_d = load ? start_i : valid_q;

  always_comb begin
    logic signed [DIFF_BITS-1:0] x, p0, p1, p2;
    int s;
    item_d = '0;
    for (int l = 0; l < LANES; l++) begin
      s  = l % SETS;
      x  = (l < SETS) ? DIFF_BITS'(item_i.angle_sample) : DIFF_BITS'(item_i.rate_sample);
      p0 = DIFF_BITS'(get_point(cfg_i, l / SETS, 3 * s));
      p1 = DIFF_BITS'(get_point(cfg_i, l / SETS, 3 * s + 1));
      p2 = DIFF_BITS'(get_point(cfg_i, l / SETS, 3 * s + 2));
      item_d.one[l] = 1'b0;
      item_d.num[l] = '0;
      item_d.den[l] = SPAN_BITS'(1);
      if (s == 0) begin
        if (x < p1) begin
          item_d.one[l] = 1'b1;
        end else if (x < p2) begin
          item_d.num[l] = SPAN_BITS'(p2 - x);
          item_d.den[l] = SPAN_BITS'(p2 - p1);
        end
      end else if (s == SETS - 1) begin
        if (x >= p1) begin
          item_d.one[l] = 1'b1;
        end else if (x >= p0) begin
          item_d.num[l] = SPAN_BITS'(x - p0);
          item_d.den[l] = SPAN_BITS'(p1 - p0);
        end
      end else begin
        if (x >= p0 && x < p1) begin
          item_d.num[l] = SPAN_BITS'(x - p0);
          item_d.den[l] = SPAN_BITS'(p1 - p0);
        end else if (x >= p1 && x < p2) begin
          item_d.num[l] = SPAN_BITS'(p2 - x);
          item_d.den[l] = SPAN_BITS'(p2 - p1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load && start_i) item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== sv/fzc_queue.sv =====
module fzc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  fzc_pkg::front_item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output fzc_pkg::front_item_t item_o
);
  import fzc_pkg::*;

  localparam int PTR_BITS = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_BITS = $clog2(QDEPTH + 1);

  front_item_t         mem_q [QDEPTH];
  logic [PTR_BITS-1:0] wp_q, rp_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic                push, pop;

  assign ready_o = cnt_q != CNT_BITS'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign push    = valid_i && ready_o;
  assign pop     = valid_o;
  assign item_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PTR_BITS'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == PTR_BITS'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CNT_BITS'(push) - CNT_BITS'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= item_i;
  end
endmodule

// ===== sv/fzc_back.sv =====
module fzc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  fzc_pkg::front_item_t item_i,
  input  fzc_pkg::cfg_t        cfg_i,
  output logic                 valid_o,
  output fzc_pkg::out_item_t   res_o
);
  import fzc_pkg::*;

  function automatic logic [SPAN_BITS:0] div_step(input logic [SPAN_BITS-1:0] r,
                                                  input logic [SPAN_BITS-1:0] d);
    logic [SPAN_BITS:0] t;
    t = {r, 1'b0};
    if (t >= {1'b0, d}) return {1'b1, SPAN_BITS'(t - {1'b0, d})};
    else return {1'b0, t[SPAN_BITS-1:0]};
  endfunction

  function automatic logic [2*SQRT_BITS-1:0] sqrt_step(input logic [SQRT_BITS-1:0] v,
                                                       input logic [SQRT_BITS-1:0] r,
                                                       input int k);
    logic [SQRT_BITS-1:0] b;
    b = SQRT_BITS'(1) << (2 * (SQRT_STEPS - 1 - k));
    if (v >= r + b) return {SQRT_BITS'(v - (r + b)), SQRT_BITS'((r >> 1) + b)};
    else return {v, SQRT_BITS'(r >> 1)};
  endfunction

  logic [BACK_STAGES-1:0] vld_q;

  // fuzzify dividers
  logic [SPAN_BITS-1:0]     dr_q [DIV_STEPS][LANES], dr_d [DIV_STEPS][LANES];
  logic [SPAN_BITS-1:0]     dd_q [DIV_STEPS][LANES], dd_d [DIV_STEPS][LANES];
  logic [FRACTION_BITS-1:0] dq_q [DIV_STEPS][LANES], dq_d [DIV_STEPS][LANES];
  logic                     do_q [DIV_STEPS][LANES], do_d [DIV_STEPS][LANES];

  always_comb begin
    logic [SPAN_BITS:0] st;
    for (int l = 0; l < LANES; l++) begin
      st = div_step(item_i.num[l], item_i.den[l]);
      dr_d[0][l] = st[SPAN_BITS-1:0];
      dq_d[0][l] = FRACTION_BITS'(st[SPAN_BITS]);
      dd_d[0][l] = item_i.den[l];
      do_d[0][l] = item_i.one[l];
      for (int k = 1; k < DIV_STEPS; k++) begin
        st = div_step(dr_q[k-1][l], dd_q[k-1][l]);
        dr_d[k][l] = st[SPAN_BITS-1:0];
        dq_d[k][l] = FRACTION_BITS'({dq_q[k-1][l], st[SPAN_BITS]});
        dd_d[k][l] = dd_q[k-1][l];
        do_d[k][l] = do_q[k-1][l];
      end
    end
  end

  // rule strengths, squared, summed per output set
  logic [MF_BITS-1:0]   mf [LANES];
  logic [SQ_BITS-1:0]   sq_q [RULES], sq_d [RULES];
  logic [PART_BITS-1:0] part_q [SETS][SETS], part_d [SETS][SETS];
  logic [ACC_BITS-1:0]  acc_q [SETS], acc_d [SETS];

  always_comb begin
    logic [MF_BITS-1:0] a, b, m;
    for (int l = 0; l < LANES; l++) begin
      mf[l] = do_q[DIV_STEPS-1][l] ? MF_BITS'(1) << FRACTION_BITS
                                   : MF_BITS'(dq_q[DIV_STEPS-1][l]);
    end
    for (int r = 0; r < RULES; r++) begin
      a = mf[r % SETS];
      b = mf[SETS + r / SETS];
      m = (a < b) ? a : b;
      sq_d[r] = SQ_BITS'(m) * SQ_BITS'(m);
    end
    for (int k = 0; k < SETS; k++) begin
      acc_d[k] = '0;
      for (int row = 0; row < SETS; row++) begin
        part_d[k][row] = '0;
        for (int c = 0; c < SETS; c++) begin
          if (rule_code(cfg_i, row * SETS + c) == CODE_BITS'(k))
            part_d[k][row] = part_d[k][row] + PART_BITS'(sq_q[row * SETS + c]);
        end
        acc_d[k] = acc_d[k] + ACC_BITS'(part_q[k][row]);
      end
    end
  end

  // square roots
  logic [SQRT_BITS-1:0] sv_q [SQRT_STEPS][SETS], sv_d [SQRT_STEPS][SETS];
  logic [SQRT_BITS-1:0] sr_q [SQRT_STEPS][SETS], sr_d [SQRT_STEPS][SETS];

  always_comb begin
    logic [2*SQRT_BITS-1:0] t;
    for (int s = 0; s < SETS; s++) begin
      t = sqrt_step(SQRT_BITS'(acc_q[s]), '0, 0);
      sv_d[0][s] = t[2*SQRT_BITS-1:SQRT_BITS];
      sr_d[0][s] = t[SQRT_BITS-1:0];
      for (int k = 1; k < SQRT_STEPS; k++) begin
        t = sqrt_step(sv_q[k-1][s], sr_q[k-1][s], k);
        sv_d[k][s] = t[2*SQRT_BITS-1:SQRT_BITS];
        sr_d[k][s] = t[SQRT_BITS-1:0];
      end
    end
  end

  // weighted average setup
  logic [DEN_BITS-1:0] d0_den_q, d0_den_d;
  logic [DVD_BITS-1:0] d0_dvd_q, d0_dvd_d;
  logic                d0_neg_q, d0_neg_d, d0_zero_q, d0_zero_d;

  always_comb begin
    logic [STR_BITS-1:0] s [SETS];
    logic [MAG_BITS-1:0] pos, negs, mag;
    for (int k = 0; k < SETS; k++) s[k] = sr_q[SQRT_STEPS-1][k][STR_BITS-1:0];
    d0_den_d = '0;
    for (int k = 0; k < SETS; k++) d0_den_d = d0_den_d + DEN_BITS'(s[k]);
    pos  = MAG_BITS'(s[4]) * MAG_BITS'(WEIGHT_BIG) + MAG_BITS'(s[3]);
    negs = MAG_BITS'(s[0]) * MAG_BITS'(WEIGHT_BIG) + MAG_BITS'(s[1]);
    d0_neg_d  = negs > pos;
    mag       = d0_neg_d ? negs - pos : pos - negs;
    d0_zero_d = d0_den_d == '0;
    d0_dvd_d  = (DVD_BITS'(mag) << FRACTION_BITS) + DVD_BITS'(d0_den_d >> 1);
  end

  // final divider
  logic [DEN_BITS-1:0]  qr_q [QUO_STEPS], qr_d [QUO_STEPS];
  logic [DEN_BITS-1:0]  qd_q [QUO_STEPS], qd_d [QUO_STEPS];
  logic [QUO_STEPS-1:0] ql_q [QUO_STEPS], ql_d [QUO_STEPS];
  logic [QUO_STEPS-1:0] qq_q [QUO_STEPS], qq_d [QUO_STEPS];
  logic                 qn_q [QUO_STEPS], qn_d [QUO_STEPS];
  logic                 qz_q [QUO_STEPS], qz_d [QUO_STEPS];
  out_item_t            res_q, res_d;

  always_comb begin
    logic [DEN_BITS-1:0]  r, d;
    logic [QUO_STEPS-1:0] lo, q;
    logic [DEN_BITS:0]    t;
    logic                 ge;
    for (int k = 0; k < QUO_STEPS; k++) begin
      if (k == 0) begin
        r  = DEN_BITS'(d0_dvd_q >> QUO_STEPS);
        lo = d0_dvd_q[QUO_STEPS-1:0];
        q  = '0;
        d  = d0_den_q;
        qn_d[k] = d0_neg_q;
        qz_d[k] = d0_zero_q;
      end else begin
        r  = qr_q[k-1];
        lo = ql_q[k-1];
        q  = qq_q[k-1];
        d  = qd_q[k-1];
        qn_d[k] = qn_q[k-1];
        qz_d[k] = qz_q[k-1];
      end
      t  = {r, lo[QUO_STEPS-1]};
      ge = t >= {1'b0, d};
      qr_d[k] = ge ? DEN_BITS'(t - {1'b0, d}) : t[DEN_BITS-1:0];
      ql_d[k] = lo << 1;
      qq_d[k] = {q[QUO_STEPS-2:0], ge};
      qd_d[k] = d;
    end
    res_d.no_rule_fired = qz_q[QUO_STEPS-1];
    if (qz_q[QUO_STEPS-1]) res_d.drive_value = '0;
    else if (qn_q[QUO_STEPS-1])
      res_d.drive_value = -DRIVE_BITS'(qq_q[QUO_STEPS-1]);
    else res_d.drive_value = DRIVE_BITS'(qq_q[QUO_STEPS-1]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[BACK_STAGES-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    dr_q <= dr_d;
    dd_q <= dd_d;
    dq_q <= dq_d;
    do_q <= do_d;
    sq_q <= sq_d;
    part_q <= part_d;
    acc_q <= acc_d;
    sv_q <= sv_d;
    sr_q <= sr_d;
    d0_den_q <= d0_den_d;
    d0_dvd_q <= d0_dvd_d;
    d0_neg_q <= d0_neg_d;
    d0_zero_q <= d0_zero_d;
    qr_q <= qr_d;
    qd_q <= qd_d;
    ql_q <= ql_d;
    qq_q <= qq_d;
    qn_q <= qn_d;
    qz_q <= qz_d;
    res_q <= res_d;
  end

  assign valid_o = vld_q[BACK_STAGES-1];
  assign res_o   = res_q;
endmodule

// ===== sv/fuzzy_angle_rate_controller.sv =====
// result path: front register, queue entry, then the back pipeline and its result register
// throughput: one transaction per cycle, set by the fully pipelined dividers and root units
// busy stays low in operation since the back pipeline never stalls
// reset: asynchronous active low, clears control state and loads the default rule table
module fuzzy_angle_rate_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  fzc_pkg::in_item_t                   in_i,
  output logic                                res_valid_o,
  output fzc_pkg::out_item_t                  res_o,
  input  logic                                cfg_we_i,
  input  logic [fzc_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [fzc_pkg::CFG_BITS-1:0]        cfg_wdata_i
);
  import fzc_pkg::*;
  `include "fuzzy_angle_rate_controller_macros.svh"

  cfg_t        cfg_q;
  logic        f_valid, q_ready, q_valid;
  front_item_t f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle     <= '0;
      cfg_q.rate      <= '0;
      cfg_q.rule_low  <= RULE_LOW_RESET;
      cfg_q.rule_high <= RULE_HIGH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ANGLE_A:   cfg_q.angle[0] <= cfg_wdata_i;
        CFG_ANGLE_B:   cfg_q.angle[1] <= cfg_wdata_i;
        CFG_ANGLE_C:   cfg_q.angle[2] <= cfg_wdata_i;
        CFG_RATE_A:    cfg_q.rate[0] <= cfg_wdata_i;
        CFG_RATE_B:    cfg_q.rate[1] <= cfg_wdata_i;
        CFG_RATE_C:    cfg_q.rate[2] <= cfg_wdata_i;
        CFG_RULE_LOW:  cfg_q.rule_low <= cfg_wdata_i[RULE_LOW_BITS-1:0];
        CFG_RULE_HIGH: cfg_q.rule_high <= cfg_wdata_i[RULE_HIGH_BITS-1:0];
      endcase
    end
  end

  fzc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .item_i  (in_i),
    .busy_o  (busy),
    .cfg_i   (cfg_q),
    .valid_o (f_valid),
    .item_o  (f_item),
    .ready_i (q_ready)
  );

  fzc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_valid),
    .item_i  (f_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  fzc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (q_item),
    .cfg_i   (cfg_q),
    .valid_o (res_valid_o),
    .res_o   (res_o)
  );

  `FZC_ASSERT_NEVER(a_never_busy, busy)
  `FZC_ASSERT_IMPL(a_empty_drive_zero, res_valid_o && res_o.no_rule_fired, res_o.drive_value == '0)
  `FZC_ASSERT_IMPL(a_result_has_source, res_valid_o, $past(start && !busy, LATENCY))
  `FZC_ASSERT_IMPL(a_queue_not_full_when_front_idle, !f_valid, q_ready)
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fzc_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  in_item_t in_i;
  logic res_valid_o;
  out_item_t res_o;
  logic cfg_we_i;
  logic [CFG_INDEX_BITS-1:0] cfg_index_i;
  logic [CFG_BITS-1:0] cfg_wdata_i;

  fuzzy_angle_rate_controller dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_we_i(cfg_we_i),
    .cfg_index_i(cfg_index_i), .cfg_wdata_i(cfg_wdata_i)
  );

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES = LATENCY + 20;

  logic [CFG_BITS-1:0] angle_pts [3];
  logic [CFG_BITS-1:0] rate_pts [3];
  logic [RULE_LOW_BITS-1:0] rules_lo;
  logic [RULE_HIGH_BITS-1:0] rules_hi;

  in_item_t sample_queue[$];
  out_item_t drive_queue[$];
  int send_idle_pct;
  int mismatches;
  int idle_cycles;
  bit timed_out;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [POINT_BITS-1:0] pick_point(input bit is_rate,
                                                             input int k);
    logic [CFG_BITS-1:0] r;
    r = is_rate ? rate_pts[k / 5] : angle_pts[k / 5];
    return r[(k % 5) * POINT_BITS +: POINT_BITS];
  endfunction

  function automatic longint edge_ramp(input longint num, input longint den);
    return (num * (1 << FRACTION_BITS)) / den;
  endfunction

  function automatic void membership(input bit is_rate, input longint x,
                                     output longint mf [SETS]);
    longint p0, p1, p2, m;
    for (int s = 0; s < SETS; s++) begin
      p0 = pick_point(is_rate, 3 * s);
      p1 = pick_point(is_rate, 3 * s + 1);
      p2 = pick_point(is_rate, 3 * s + 2);
      m = 0;
      if (s == 0) begin
        if (x < p1) m = 1 << FRACTION_BITS;
        else if (x < p2) m = edge_ramp(p2 - x, p2 - p1);
      end else if (s == SETS - 1) begin
        if (x >= p1) m = 1 << FRACTION_BITS;
        else if (x >= p0) m = edge_ramp(x - p0, p1 - p0);
      end else begin
        if (x >= p0 && x < p1) m = edge_ramp(x - p0, p1 - p0);
        else if (x >= p1 && x < p2) m = edge_ramp(p2 - x, p2 - p1);
      end
      mf[s] = m;
    end
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint res, b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic out_item_t predict_drive(input in_item_t it);
    longint amf [SETS];
    longint rmf [SETS];
    longint acc [SETS];
    longint st, den, num, mag, drv;
    int code;
    longint weight [SETS] = '{-10, -1, 0, 1, 10};
    out_item_t o;
    membership(1'b0, longint'(it.angle_sample), amf);
    membership(1'b1, longint'(it.rate_sample), rmf);
    for (int k = 0; k < SETS; k++) acc[k] = 0;
    for (int r = 0; r < RULES; r++) begin
      st = (amf[r % 5] < rmf[r / 5]) ? amf[r % 5] : rmf[r / 5];
      if (r < RULES_LOW) code = int'(rules_lo[3 * r +: 3]);
      else code = int'(rules_hi[3 * (r - RULES_LOW) +: 3]);
      if (code < SETS) acc[code] += st * st;
    end
    den = 0;
    num = 0;
    for (int k = 0; k < SETS; k++) begin
      st = int_sqrt(acc[k]);
      den += st;
      num += weight[k] * st;
    end
    if (den == 0) begin
      o.drive_value = '0;
      o.no_rule_fired = 1'b1;
      return o;
    end
    mag = (num < 0) ? -num : num;
    mag = ((mag << FRACTION_BITS) + den / 2) / den;
    if (mag > 8192) mag = 8192;
    drv = (num < 0) ? -mag : mag;
    if (drv > 4095) drv = 4095;
    if (drv < -4096) drv = -4096;
    o.drive_value = drv[DRIVE_BITS-1:0];
    o.no_rule_fired = 1'b0;
    return o;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      in_i <= '0;
    end else begin
      if (start && !busy) drive_queue.push_back(predict_drive(in_i));
      if ((!start || !busy) && sample_queue.size() > 0 &&
          $urandom_range(99, 0) >= send_idle_pct) begin
        start <= 1'b1;
        in_i <= sample_queue.pop_front();
      end else if (!start || !busy) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (res_valid_o) begin
        if (drive_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", res_o);
        end else begin
          out_item_t exp_o;
          exp_o = drive_queue.pop_front();
          if (exp_o.drive_value !== res_o.drive_value ||
              exp_o.no_rule_fired !== res_o.no_rule_fired) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected drive %0d flag %0b, got drive %0d flag %0b",
                       exp_o.drive_value, exp_o.no_rule_fired,
                       res_o.drive_value, res_o.no_rule_fired);
          end
        end
      end
      if (idle_cycles > WATCHDOG_LIMIT) timed_out = 1'b1;
    end
  end

  function automatic logic [POINT_BITS-1:0] rnd_point();
    return POINT_BITS'($urandom_range(4095, 0));
  endfunction

  // ordered set points spread over a span with random jitter
  function automatic logic [CFG_BITS-1:0] pack_points(input int base, input int stepw,
                                                     input int first);
    logic [CFG_BITS-1:0] v;
    int p;
    for (int j = 0; j < 5; j++) begin
      p = base + (first + j) * stepw + int'($urandom_range(stepw / 2, 0));
      if (p > 2047) p = 2047;
      if (p < -2048) p = -2048;
      v[j * POINT_BITS +: POINT_BITS] = p[POINT_BITS-1:0];
    end
    return v;
  endfunction

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ANGLE_A: angle_pts[0] = val;
      CFG_ANGLE_B: angle_pts[1] = val;
      CFG_ANGLE_C: angle_pts[2] = val;
      CFG_RATE_A: rate_pts[0] = val;
      CFG_RATE_B: rate_pts[1] = val;
      CFG_RATE_C: rate_pts[2] = val;
      CFG_RULE_LOW: rules_lo = val[RULE_LOW_BITS-1:0];
      default: rules_hi = val[RULE_HIGH_BITS-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_queue.size() > 0 || start || drive_queue.size() > 0) begin
      @(posedge clk_i);
      if (timed_out) begin
        $display("TEST FAILED");
        $finish;
      end
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_tables(input int mode);
    int base, stepw;
    base = (mode == 0) ? -2048 : -int'($urandom_range(1500, 100));
    stepw = (mode == 0) ? 273 : -base * 2 / 15 + 1;
    for (int a = 0; a < 2; a++) begin
      for (int g = 0; g < 3; g++) begin
        logic [CFG_BITS-1:0] v;
        if (mode == 2 && $urandom_range(1, 0)) begin
          for (int j = 0; j < 5; j++) v[j * POINT_BITS +: POINT_BITS] = rnd_point();
        end else if (mode == 3) begin
          v = (g == 1) ? '0 : '1;
        end else begin
          v = pack_points(base, stepw, g * 5);
        end
        write_reg(cfg_index_e'(a * 3 + g), v);
      end
    end
    if (mode == 0) begin
      write_reg(CFG_RULE_LOW, CFG_BITS'(RULE_LOW_RESET));
      write_reg(CFG_RULE_HIGH, CFG_BITS'(RULE_HIGH_RESET));
    end else if (mode == 3) begin
      write_reg(CFG_RULE_LOW, '1);
      write_reg(CFG_RULE_HIGH, '0);
    end else begin
      write_reg(CFG_RULE_LOW, CFG_BITS'({$urandom(), $urandom()}));
      write_reg(CFG_RULE_HIGH, CFG_BITS'({$urandom(), $urandom()}));
    end
  endtask

  function automatic in_item_t rnd_sample();
    in_item_t it;
    it.angle_sample = SAMPLE_BITS'($urandom_range(4095, 0));
    it.rate_sample = SAMPLE_BITS'($urandom_range(4095, 0));
    if ($urandom_range(3, 0) == 0) it.angle_sample = SAMPLE_BITS'($urandom_range(4095, 3800));
    if ($urandom_range(3, 0) == 0) it.rate_sample = SAMPLE_BITS'($urandom_range(300, 0));
    return it;
  endfunction

  initial begin
    in_item_t it;
    logic signed [SAMPLE_BITS-1:0] edges [4];
    edges = '{SAMPLE_BITS'(-2048), SAMPLE_BITS'(2047), SAMPLE_BITS'(0), SAMPLE_BITS'(-1)};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_wdata_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    send_idle_pct = 25;
    angle_pts = '{default: '0};
    rate_pts = '{default: '0};
    rules_lo = RULE_LOW_RESET;
    rules_hi = RULE_HIGH_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-zero points at reset state
    for (int i = 0; i < 4; i++) begin
      it.angle_sample = edges[i];
      it.rate_sample = edges[3 - i];
      sample_queue.push_back(it);
    end
    wait_drained();
    load_tables(0);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        it.angle_sample = edges[i];
        it.rate_sample = edges[j];
        sample_queue.push_back(it);
      end
    end
    wait_drained();
    load_tables(3);
    for (int i = 0; i < 4; i++) sample_queue.push_back(rnd_sample());
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 25 : ((ph < 8) ? 70 : 0);
      load_tables((ph % 3 == 2) ? 2 : 1);
      for (int i = 0; i < 127; i++) sample_queue.push_back(rnd_sample());
      wait_drained();
    end

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/fzc_pkg.sv
sv/fzc_front.sv
sv/fzc_queue.sv
sv/fzc_back.sv
sv/fuzzy_angle_rate_controller.sv
bench/tb_top.sv
